// ----- sv/box_overlap_side_classifier_core_macros.svh -----
// ---------------------------------------------------------------------------
// box overlap side classifier assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef BOX_OVERLAP_SIDE_CLASSIFIER_CORE_MACROS_SVH
`define BOX_OVERLAP_SIDE_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define BOSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define BOSC_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- sv/bosc_pkg.sv -----
// ---------------------------------------------------------------------------
// bosc_pkg
// shared types and point tables for the box overlap side classifier
// ---------------------------------------------------------------------------
package bosc_pkg;

  localparam int NUM_PTS = 8;
  localparam int IDX_W   = $clog2(NUM_PTS);
  localparam int NUM_SEL = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       sel_t;

  // edge or midpoint of box b along one axis
  localparam sel_t SEL_LO  = 2'd0;
  localparam sel_t SEL_MID = 2'd1;
  localparam sel_t SEL_HI  = 2'd2;

  // reference points clockwise from top-left
  localparam sel_t PX_SEL [NUM_PTS] = '{SEL_LO, SEL_MID, SEL_HI, SEL_HI,
                                        SEL_HI, SEL_MID, SEL_LO, SEL_LO};
  localparam sel_t PY_SEL [NUM_PTS] = '{SEL_LO, SEL_LO, SEL_LO, SEL_MID,
                                        SEL_HI, SEL_HI, SEL_HI, SEL_MID};

  typedef struct packed {
    logic valid;
    logic hit;
  } ctl_t;

endpackage

// ----- sv/bosc_geom.sv -----
// ---------------------------------------------------------------------------
// bosc_geom
// overlap test, doubled-scale centre and edges, then absolute axis distances
// ---------------------------------------------------------------------------
module bosc_geom #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               valid_i,
  input  logic signed [COORD_BITS-1:0]       a_left_i,
  input  logic signed [COORD_BITS-1:0]       a_top_i,
  input  logic        [COORD_BITS-2:0]       a_width_i,
  input  logic        [COORD_BITS-2:0]       a_height_i,
  input  logic signed [COORD_BITS-1:0]       b_left_i,
  input  logic signed [COORD_BITS-1:0]       b_top_i,
  input  logic        [COORD_BITS-2:0]       b_width_i,
  input  logic        [COORD_BITS-2:0]       b_height_i,
  output bosc_pkg::ctl_t                     ctl_o,
  output logic [bosc_pkg::NUM_SEL-1:0][COORD_BITS+1:0] dx_o,
  output logic [bosc_pkg::NUM_SEL-1:0][COORD_BITS+1:0] dy_o
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS + 2;

  typedef logic signed [EW-1:0] crd_t;

  crd_t al, at, aw, ah, bl, bt, bw, bh;

  bosc_pkg::ctl_t ctl_nxt, ctl1_r, ctl2_r;
  crd_t           cx_nxt, cy_nxt, cx_r, cy_r;
  crd_t           x_nxt [bosc_pkg::NUM_SEL];
  crd_t           y_nxt [bosc_pkg::NUM_SEL];
  crd_t           x_r   [bosc_pkg::NUM_SEL];
  crd_t           y_r   [bosc_pkg::NUM_SEL];

  logic signed [EW:0] ddx [bosc_pkg::NUM_SEL];
  logic signed [EW:0] ddy [bosc_pkg::NUM_SEL];
  logic [bosc_pkg::NUM_SEL-1:0][EW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;

  // stage 1: overlap and doubled-scale geometry
  always_comb begin
    al = {{2{a_left_i[CW-1]}}, a_left_i};
    at = {{2{a_top_i[CW-1]}}, a_top_i};
    bl = {{2{b_left_i[CW-1]}}, b_left_i};
    bt = {{2{b_top_i[CW-1]}}, b_top_i};
    aw = {3'b000, a_width_i};
    ah = {3'b000, a_height_i};
    bw = {3'b000, b_width_i};
    bh = {3'b000, b_height_i};

    ctl_nxt.valid = valid_i;
    ctl_nxt.hit   = (al + aw > bl) && (al < bl + bw) &&
                    (at + ah > bt) && (at < bt + bh);

    cx_nxt = (al <<< 1) + aw;
    cy_nxt = (at <<< 1) + ah;
    x_nxt[bosc_pkg::SEL_LO]  = bl <<< 1;
    x_nxt[bosc_pkg::SEL_MID] = (bl <<< 1) + bw;
    x_nxt[bosc_pkg::SEL_HI]  = (bl <<< 1) + (bw <<< 1);
    y_nxt[bosc_pkg::SEL_LO]  = bt <<< 1;
    y_nxt[bosc_pkg::SEL_MID] = (bt <<< 1) + bh;
    y_nxt[bosc_pkg::SEL_HI]  = (bt <<< 1) + (bh <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
    end else begin
      ctl1_r.valid <= ctl_nxt.valid;
    end
    ctl1_r.hit <= ctl_nxt.hit;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
  end

  // stage 2: absolute distances on each axis
  always_comb begin
    for (int k = 0; k < bosc_pkg::NUM_SEL; k++) begin
      ddx[k] = {cx_r[EW-1], cx_r} - {x_r[k][EW-1], x_r[k]};
      ddy[k] = {cy_r[EW-1], cy_r} - {y_r[k][EW-1], y_r[k]};
      dx_nxt[k] = ddx[k][EW] ? EW'(-ddx[k]) : ddx[k][EW-1:0];
      dy_nxt[k] = ddy[k][EW] ? EW'(-ddy[k]) : ddy[k][EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.valid <= 1'b0;
    end else begin
      ctl2_r.valid <= ctl1_r.valid;
    end
    ctl2_r.hit <= ctl1_r.hit;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
  end

  assign ctl_o = ctl2_r;
  assign dx_o  = dx_r;
  assign dy_o  = dy_r;

endmodule

// ----- sv/bosc_dist.sv -----
// ---------------------------------------------------------------------------
// bosc_dist
// squares of the axis distances, then squared distance to each point
// ---------------------------------------------------------------------------
module bosc_dist #(
  parameter int COORD_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  bosc_pkg::ctl_t                                  ctl_i,
  input  logic [bosc_pkg::NUM_SEL-1:0][COORD_BITS+1:0]    dx_i,
  input  logic [bosc_pkg::NUM_SEL-1:0][COORD_BITS+1:0]    dy_i,
  output bosc_pkg::ctl_t                                  ctl_o,
  output logic [bosc_pkg::NUM_PTS-1:0][2*COORD_BITS+4:0]  d_o
);

  localparam int EW = COORD_BITS + 2;
  localparam int SW = 2 * EW;
  localparam int DW = SW + 1;

  bosc_pkg::ctl_t ctl3_r, ctl4_r;
  logic [SW-1:0]  sqx_nxt [bosc_pkg::NUM_SEL];
  logic [SW-1:0]  sqy_nxt [bosc_pkg::NUM_SEL];
  logic [SW-1:0]  sqx_r   [bosc_pkg::NUM_SEL];
  logic [SW-1:0]  sqy_r   [bosc_pkg::NUM_SEL];
  logic [bosc_pkg::NUM_PTS-1:0][DW-1:0] d_nxt, d_r;

  // stage 3: squarers
  always_comb begin
    for (int k = 0; k < bosc_pkg::NUM_SEL; k++) begin
      sqx_nxt[k] = SW'(dx_i[k]) * SW'(dx_i[k]);
      sqy_nxt[k] = SW'(dy_i[k]) * SW'(dy_i[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= ctl_i.valid;
    end
    ctl3_r.hit <= ctl_i.hit;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
  end

  // stage 4: per-point sums
  always_comb begin
    for (int i = 0; i < bosc_pkg::NUM_PTS; i++) begin
      d_nxt[i] = DW'(sqx_r[bosc_pkg::PX_SEL[i]]) + DW'(sqy_r[bosc_pkg::PY_SEL[i]]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r.valid <= 1'b0;
    end else begin
      ctl4_r.valid <= ctl3_r.valid;
    end
    ctl4_r.hit <= ctl3_r.hit;
    d_r        <= d_nxt;
  end

  assign ctl_o = ctl4_r;
  assign d_o   = d_r;

endmodule

// ----- sv/bosc_argmin.sv -----
// ---------------------------------------------------------------------------
// bosc_argmin
// registered three-level compare tree, lowest index wins on a tie
// ---------------------------------------------------------------------------
module bosc_argmin #(
  parameter int COORD_BITS = 16
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  bosc_pkg::ctl_t                                  ctl_i,
  input  logic [bosc_pkg::NUM_PTS-1:0][2*COORD_BITS+4:0]  d_i,
  output logic                                            valid_o,
  output logic                                            overlap_o,
  output bosc_pkg::idx_t                                  side_o
);

  localparam int DW = 2 * COORD_BITS + 5;
  localparam int N1 = bosc_pkg::NUM_PTS / 2;
  localparam int N2 = bosc_pkg::NUM_PTS / 4;

  bosc_pkg::ctl_t ctl5_r, ctl6_r;
  logic [N1-1:0][DW-1:0] c1d_nxt, c1d_r;
  logic [N2-1:0][DW-1:0] c2d_nxt, c2d_r;
  bosc_pkg::idx_t        c1i_nxt [N1];
  bosc_pkg::idx_t        c1i_r   [N1];
  bosc_pkg::idx_t        c2i_nxt [N2];
  bosc_pkg::idx_t        c2i_r   [N2];
  logic                  tb1 [N1];
  logic                  tb2 [N2];
  logic                  tb3;
  bosc_pkg::idx_t        side_nxt, side_r;
  logic                  valid_r, overlap_r;

  // stage 5: pairs of points
  always_comb begin
    for (int k = 0; k < N1; k++) begin
      tb1[k]     = d_i[2*k+1] < d_i[2*k];
      c1d_nxt[k] = tb1[k] ? d_i[2*k+1] : d_i[2*k];
      c1i_nxt[k] = tb1[k] ? bosc_pkg::idx_t'(2*k+1) : bosc_pkg::idx_t'(2*k);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r.valid <= 1'b0;
    end else begin
      ctl5_r.valid <= ctl_i.valid;
    end
    ctl5_r.hit <= ctl_i.hit;
    c1d_r      <= c1d_nxt;
    c1i_r      <= c1i_nxt;
  end

  // stage 6: pairs of pairs
  always_comb begin
    for (int m = 0; m < N2; m++) begin
      tb2[m]     = c1d_r[2*m+1] < c1d_r[2*m];
      c2d_nxt[m] = tb2[m] ? c1d_r[2*m+1] : c1d_r[2*m];
      c2i_nxt[m] = tb2[m] ? c1i_r[2*m+1] : c1i_r[2*m];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r.valid <= 1'b0;
    end else begin
      ctl6_r.valid <= ctl5_r.valid;
    end
    ctl6_r.hit <= ctl5_r.hit;
    c2d_r      <= c2d_nxt;
    c2i_r      <= c2i_nxt;
  end

  // stage 7: final pick into the result register
  always_comb begin
    tb3      = c2d_r[1] < c2d_r[0];
    side_nxt = '0;
    if (ctl6_r.hit) begin
      side_nxt = tb3 ? c2i_r[1] : c2i_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl6_r.valid;
    end
    overlap_r <= ctl6_r.hit;
    side_r    <= side_nxt;
  end

  assign valid_o   = valid_r;
  assign overlap_o = overlap_r;
  assign side_o    = side_r;

endmodule

// ----- sv/box_overlap_side_classifier_core.sv -----
// ---------------------------------------------------------------------------
// box_overlap_side_classifier_core
// strict overlap test of two boxes and nearest reference point of box b
// ---------------------------------------------------------------------------
// One box pair is taken on every clock in which start is high; busy is never
// raised. Each transaction yields one result, shown for a single cycle with
// out_valid; the receiver cannot hold it off and nothing is buffered. The
// pipeline has seven register stages: edges and overlap, axis distances,
// squarers, per-point sums and a three-level compare tree. Side index is 0
// when the boxes do not overlap.
`include "box_overlap_side_classifier_core_macros.svh"

module box_overlap_side_classifier_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_a_left,
  input  logic signed [COORD_BITS-1:0] in_a_top,
  input  logic        [COORD_BITS-2:0] in_a_width,
  input  logic        [COORD_BITS-2:0] in_a_height,
  input  logic signed [COORD_BITS-1:0] in_b_left,
  input  logic signed [COORD_BITS-1:0] in_b_top,
  input  logic        [COORD_BITS-2:0] in_b_width,
  input  logic        [COORD_BITS-2:0] in_b_height,
  output logic                         out_valid,
  output logic                         out_overlap,
  output logic [2:0]                   out_side_index
);

  localparam int PIPE_LAT = 7;

  bosc_pkg::ctl_t ctl_g, ctl_d;
  logic [bosc_pkg::NUM_SEL-1:0][COORD_BITS+1:0]   dx, dy;
  logic [bosc_pkg::NUM_PTS-1:0][2*COORD_BITS+4:0] pt_dist;
  bosc_pkg::idx_t side;

  assign busy = 1'b0;

  bosc_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (start && !busy),
    .a_left_i   (in_a_left),
    .a_top_i    (in_a_top),
    .a_width_i  (in_a_width),
    .a_height_i (in_a_height),
    .b_left_i   (in_b_left),
    .b_top_i    (in_b_top),
    .b_width_i  (in_b_width),
    .b_height_i (in_b_height),
    .ctl_o      (ctl_g),
    .dx_o       (dx),
    .dy_o       (dy)
  );

  bosc_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_g),
    .dx_i  (dx),
    .dy_i  (dy),
    .ctl_o (ctl_d),
    .d_o   (pt_dist)
  );

  bosc_argmin #(
    .COORD_BITS (COORD_BITS)
  ) u_argmin (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl_d),
    .d_i       (pt_dist),
    .valid_o   (out_valid),
    .overlap_o (out_overlap),
    .side_o    (side)
  );

  assign out_side_index = side;

  `BOSC_ASSERT_DLY(a_result_follows, start && !busy, PIPE_LAT, out_valid, "transaction lost")
  `BOSC_ASSERT_IMP(a_no_spurious, out_valid, $past(start && !busy, PIPE_LAT), "spurious result")
  `BOSC_ASSERT_IMP(a_miss_index, out_valid && !out_overlap, out_side_index == '0, "index on a miss")

endmodule

// ----- test/box_overlap_side_classifier_core_test.sv -----
// ---------------------------------------------------------------------------
// box_overlap_side_classifier_core_test
// drives box pairs through the classifier with random start gaps and checks
// every overlap flag and nearest reference point against an own predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module box_overlap_side_classifier_core_test;

  localparam int CB            = 16;
  localparam int RANDOM_PAIRS  = 1150;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 2000;

  typedef struct {
    logic signed [CB-1:0] a_left;
    logic signed [CB-1:0] a_top;
    logic        [CB-2:0] a_width;
    logic        [CB-2:0] a_height;
    logic signed [CB-1:0] b_left;
    logic signed [CB-1:0] b_top;
    logic        [CB-2:0] b_width;
    logic        [CB-2:0] b_height;
  } box_pair_t;

  typedef struct {
    logic           overlap;
    bosc_pkg::idx_t side;
  } verdict_t;

  class side_scoreboard;
    verdict_t pending_verdicts[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    // strict overlap, then nearest of the eight points of b at doubled scale
    function void note_pair(box_pair_t p);
      longint al, at, aw, ah, bl, bt, bw, bh;
      longint cx, cy, dx, dy, sq_dist, best_dist;
      longint px[bosc_pkg::NUM_PTS];
      longint py[bosc_pkg::NUM_PTS];
      verdict_t v;
      al = p.a_left;
      at = p.a_top;
      aw = p.a_width;
      ah = p.a_height;
      bl = p.b_left;
      bt = p.b_top;
      bw = p.b_width;
      bh = p.b_height;
      v.overlap = (al + aw > bl) && (al < bl + bw) && (at + ah > bt) && (at < bt + bh);
      v.side = '0;
      if (v.overlap) begin
        cx = 2 * al + aw;
        cy = 2 * at + ah;
        px = '{2 * bl, 2 * bl + bw, 2 * bl + 2 * bw, 2 * bl + 2 * bw,
               2 * bl + 2 * bw, 2 * bl + bw, 2 * bl, 2 * bl};
        py = '{2 * bt, 2 * bt, 2 * bt, 2 * bt + bh,
               2 * bt + 2 * bh, 2 * bt + 2 * bh, 2 * bt + 2 * bh, 2 * bt + bh};
        best_dist = 0;
        for (int i = 0; i < bosc_pkg::NUM_PTS; i++) begin
          dx = cx - px[i];
          dy = cy - py[i];
          sq_dist = dx * dx + dy * dy;
          if (i == 0 || sq_dist < best_dist) begin
            best_dist = sq_dist;
            v.side = bosc_pkg::idx_t'(i);
          end
        end
      end
      pending_verdicts.insert(pending_verdicts.size(), v);
    endfunction

    function void check_verdict(logic overlap, bosc_pkg::idx_t side);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("result with no transaction pending: overlap %0d side_index %0d", overlap, side);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        if (overlap !== v.overlap) begin
          $error("overlap: expected %0d, got %0d", v.overlap, overlap);
          errors++;
        end
        if (side !== v.side) begin
          $error("side_index: expected %0d, got %0d", v.side, side);
          errors++;
        end
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  logic           start;
  logic           busy;
  box_pair_t      stim;
  logic           out_valid;
  logic           out_overlap;
  bosc_pkg::idx_t out_side_index;

  side_scoreboard sb;
  box_pair_t      pairs[$];
  int             idle_cycles;

  box_overlap_side_classifier_core #(
    .COORD_BITS(CB)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_a_left     (stim.a_left),
    .in_a_top      (stim.a_top),
    .in_a_width    (stim.a_width),
    .in_a_height   (stim.a_height),
    .in_b_left     (stim.b_left),
    .in_b_top      (stim.b_top),
    .in_b_width    (stim.b_width),
    .in_b_height   (stim.b_height),
    .out_valid     (out_valid),
    .out_overlap   (out_overlap),
    .out_side_index(out_side_index)
  );

  always #1 clk = ~clk;

  function automatic box_pair_t mk(int al, int at, int aw, int ah,
                                   int bl, int bt, int bw, int bh);
    box_pair_t p;
    p.a_left   = CB'(al);
    p.a_top    = CB'(at);
    p.a_width  = (CB-1)'(aw);
    p.a_height = (CB-1)'(ah);
    p.b_left   = CB'(bl);
    p.b_top    = CB'(bt);
    p.b_width  = (CB-1)'(bw);
    p.b_height = (CB-1)'(bh);
    return p;
  endfunction

  function automatic void add_pair(box_pair_t p);
    pairs.insert(pairs.size(), p);
  endfunction

  // transaction monitor, result check and stall watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (start && !busy) begin
        sb.note_pair(stim);
      end
      if (out_valid) begin
        sb.check_verdict(out_overlap, out_side_index);
      end
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[box_overlap_side_classifier_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    box_pair_t p;
    box_pair_t junk;
    int        r;
    int        k;
    int        gap;
    bit        quiet;
    rst_n       = 1'b0;
    start       = 1'b0;
    stim        = mk(0, 0, 0, 0, 0, 0, 0, 0);
    quiet       = 1'b0;
    sb          = new();

    // nearest point at each of the eight positions of b
    add_pair(mk(0, 0, 2, 2, 0, 0, 100, 100));
    add_pair(mk(49, 0, 2, 2, 0, 0, 100, 100));
    add_pair(mk(98, 0, 2, 2, 0, 0, 100, 100));
    add_pair(mk(98, 49, 2, 2, 0, 0, 100, 100));
    add_pair(mk(98, 98, 2, 2, 0, 0, 100, 100));
    add_pair(mk(49, 98, 2, 2, 0, 0, 100, 100));
    add_pair(mk(0, 98, 2, 2, 0, 0, 100, 100));
    add_pair(mk(0, 49, 2, 2, 0, 0, 100, 100));
    // equal distances: identical squares and a centre between two side midpoints
    add_pair(mk(10, 10, 40, 40, 10, 10, 40, 40));
    add_pair(mk(-5, -5, 10, 10, -5, -5, 10, 10));
    add_pair(mk(0, 0, 1, 100, 0, 0, 1, 100));
    // touching edges on all four sides
    add_pair(mk(-10, 0, 10, 10, 0, 0, 10, 10));
    add_pair(mk(10, 0, 10, 10, 0, 0, 10, 10));
    add_pair(mk(0, -10, 10, 10, 0, 0, 10, 10));
    add_pair(mk(0, 10, 10, 10, 0, 0, 10, 10));
    // zero width or height
    add_pair(mk(0, 0, 0, 10, 0, 0, 10, 10));
    add_pair(mk(0, 0, 10, 10, 0, 0, 10, 0));
    add_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
    // field extremes
    add_pair(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
    add_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 1, 1));
    add_pair(mk(-32768, -32768, 32767, 32767, -100, -100, 5, 5));
    add_pair(mk(-32768, 32767, 32767, 32767, 32767, -32768, 32767, 32767));
    add_pair(mk(-1, -1, 32767, 32767, -32768, -32768, 32767, 32767));
    add_pair(mk(100, 100, 5, 5, -3000, 2000, 20, 20));

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      r = $urandom_range(99);
      p.a_left   = CB'($urandom);
      p.a_top    = CB'($urandom);
      p.a_width  = (CB-1)'($urandom);
      p.a_height = (CB-1)'($urandom);
      p.b_left   = CB'($urandom);
      p.b_top    = CB'($urandom);
      p.b_width  = (CB-1)'($urandom);
      p.b_height = (CB-1)'($urandom);
      if (r < 70) begin
        p.b_left   = CB'(int'($urandom_range(64000)) - 32000);
        p.b_top    = CB'(int'($urandom_range(64000)) - 32000);
        p.a_width  = (CB-1)'(($urandom_range(19) == 0) ? 0 : $urandom_range(300));
        p.a_height = (CB-1)'(($urandom_range(19) == 0) ? 0 : $urandom_range(300));
        p.b_width  = (CB-1)'(($urandom_range(19) == 0) ? 0 : $urandom_range(300));
        p.b_height = (CB-1)'(($urandom_range(19) == 0) ? 0 : $urandom_range(300));
        p.a_left   = CB'(p.b_left + int'($urandom_range(700)) - 350);
        p.a_top    = CB'(p.b_top + int'($urandom_range(700)) - 350);
      end
      if (r >= 55 && r < 70) begin
        // edges meeting exactly or one pixel either side
        k = $urandom_range(3);
        case (k)
          0: p.a_left = CB'(p.b_left - p.a_width + int'($urandom_range(2)) - 1);
          1: p.a_left = CB'(p.b_left + p.b_width + int'($urandom_range(2)) - 1);
          2: p.a_top = CB'(p.b_top - p.a_height + int'($urandom_range(2)) - 1);
          default: p.a_top = CB'(p.b_top + p.b_height + int'($urandom_range(2)) - 1);
        endcase
      end else if (r >= 70 && r < 85) begin
        p.a_left = CB'(p.b_left + int'($urandom_range(4000)) - 2000);
        p.a_top  = CB'(p.b_top + int'($urandom_range(4000)) - 2000);
      end
      add_pair(p);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < pairs.size(); n++) begin
      if (n % 60 == 0)
        quiet = ($urandom_range(3) == 0);
      stim  <= pairs[n];
      start <= 1'b1;
      @(negedge clk);
      while (busy)
        @(negedge clk);
      @(posedge clk);
      r = $urandom_range(99);
      if (quiet || r < 50)
        gap = 0;
      else if (r < 85)
        gap = $urandom_range(3, 1);
      else if (r < 97)
        gap = $urandom_range(10, 4);
      else
        gap = $urandom_range(40, 20);
      if (gap > 0) begin
        junk.a_left   = CB'($urandom);
        junk.a_top    = CB'($urandom);
        junk.a_width  = (CB-1)'($urandom);
        junk.a_height = (CB-1)'($urandom);
        junk.b_left   = CB'($urandom);
        junk.b_top    = CB'($urandom);
        junk.b_width  = (CB-1)'($urandom);
        junk.b_height = (CB-1)'($urandom);
        start <= 1'b0;
        stim  <= junk;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (sb.outstanding() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[box_overlap_side_classifier_core] OK");
    end else begin
      $display("[box_overlap_side_classifier_core] ERROR");
    end
    $finish;
  end

endmodule
